>>> hw/rtl/ofs_pkg.sv
package ofs_pkg;

    // Field kinds carried on item.kind
    localparam logic [2:0] KIND_UINT8   = 3'd0;
    localparam logic [2:0] KIND_UINT16  = 3'd1;
    localparam logic [2:0] KIND_UINT32  = 3'd2;
    localparam logic [2:0] KIND_UINT64  = 3'd3;
    localparam logic [2:0] KIND_VARUINT = 3'd4;
    localparam logic [2:0] KIND_FLOAT32 = 3'd5;
    localparam logic [2:0] KIND_FLOAT64 = 3'd6;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_MASK      = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDE_MASK = 8'd1;

    // Bias removed from uint64 values before they are sent
    localparam logic [63:0] UINT64_BIAS = 64'd112;

    // First position number of the wide-masked kinds
    localparam logic [2:0] POS_UINT16 = 3'd1;
    localparam logic [2:0] POS_UINT32 = 3'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] value;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } result_t;

    typedef enum logic [1:0] {
        MODE_BE  = 2'd0,   // big-endian, top byte first
        MODE_LE  = 2'd1,   // little-endian, bottom byte first
        MODE_VAR = 2'd2    // 7-bit groups, bottom group first
    } mode_t;

    // Classified field, ready for the byte emitter
    typedef struct packed {
        mode_t       mode;
        logic [63:0] data;   // BE fields are left-aligned
        logic [3:0]  count;  // bytes to send for BE and LE
        logic [7:0]  xr;     // fixed XOR applied to every byte
        logic [2:0]  pos;    // first position number, zero when unused
    } cmd_t;

endpackage

>>> hw/rtl/ofs_front.sv
module ofs_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  ofs_pkg::item_t                 item,
    input  logic                           cfg_valid,
    input  logic [ofs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    output logic                           push,
    output ofs_pkg::cmd_t                  cmd
);
    import ofs_pkg::*;

    logic [7:0] mask_reg;
    logic [7:0] wide_mask_reg;
    logic       known;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            wide_mask_reg <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_MASK)
            begin
                mask_reg <= cfg_data;
            end
            else if (cfg_index == REG_WIDE_MASK)
            begin
                wide_mask_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        cmd   = '0;
        known = 1'b1;
        unique case (item.kind)
            KIND_UINT8:
            begin
                cmd.mode  = MODE_BE;
                cmd.data  = {item.value[7:0], 56'd0};
                cmd.count = 4'd1;
                cmd.xr    = mask_reg;
            end
            KIND_UINT16:
            begin
                cmd.mode  = MODE_BE;
                cmd.data  = {item.value[15:0], 48'd0};
                cmd.count = 4'd2;
                cmd.xr    = mask_reg ^ wide_mask_reg;
                cmd.pos   = POS_UINT16;
            end
            KIND_UINT32:
            begin
                cmd.mode  = MODE_BE;
                cmd.data  = {item.value[31:0], 32'd0};
                cmd.count = 4'd4;
                cmd.xr    = mask_reg ^ wide_mask_reg;
                cmd.pos   = POS_UINT32;
            end
            KIND_UINT64:
            begin
                cmd.mode  = MODE_BE;
                cmd.data  = item.value - UINT64_BIAS;
                cmd.count = 4'd8;
                cmd.xr    = mask_reg;
            end
            KIND_VARUINT:
            begin
                cmd.mode  = MODE_VAR;
                cmd.data  = item.value;
                cmd.count = 4'd1;
                cmd.xr    = mask_reg;
            end
            KIND_FLOAT32:
            begin
                cmd.mode  = MODE_LE;
                cmd.data  = {32'd0, item.value[31:0]};
                cmd.count = 4'd4;
            end
            KIND_FLOAT64:
            begin
                cmd.mode  = MODE_LE;
                cmd.data  = item.value;
                cmd.count = 4'd8;
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    // Drop undefined kinds here: they send nothing
    assign push = accept && known;

endmodule

>>> hw/rtl/ofs_queue.sv
module ofs_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ofs_pkg::cmd_t push_cmd,
    input  logic          pop,
    output ofs_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);
    import ofs_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    cmd_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue read while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count out of range");

endmodule

>>> hw/rtl/ofs_back.sv
module ofs_back (
    input  logic             clk,
    input  logic             rst_n,
    input  ofs_pkg::cmd_t    head,
    input  logic             empty,
    output logic             pop,
    output logic             result_valid,
    output ofs_pkg::result_t result
);
    import ofs_pkg::*;

    logic        active_reg;
    logic        active_next;
    mode_t       mode_reg;
    logic [63:0] data_reg;
    logic [63:0] data_next;
    logic [3:0]  count_reg;
    logic [3:0]  count_next;
    logic [7:0]  xr_reg;
    logic [2:0]  pos_reg;
    logic [2:0]  pos_next;
    logic        valid_reg;
    result_t     result_reg;
    result_t     cur;
    logic        cont;

    // Form the byte of the current field for this cycle
    always_comb
    begin
        cont       = |data_reg[63:7];
        cur        = '0;
        data_next  = data_reg;
        count_next = count_reg - 1'b1;
        pos_next   = (pos_reg != '0) ? pos_reg + 1'b1 : pos_reg;
        unique case (mode_reg)
            MODE_BE:
            begin
                cur.out_byte = data_reg[63:56] ^ xr_reg ^ {5'd0, pos_reg};
                cur.last     = (count_reg == 4'd1);
                data_next    = {data_reg[55:0], 8'd0};
            end
            MODE_LE:
            begin
                cur.out_byte = data_reg[7:0] ^ xr_reg;
                cur.last     = (count_reg == 4'd1);
                data_next    = {8'd0, data_reg[63:8]};
            end
            MODE_VAR:
            begin
                cur.out_byte = {data_reg[6:0], cont} ^ xr_reg;
                cur.last     = !cont;
                data_next    = {7'd0, data_reg[63:7]};
                count_next   = count_reg;
            end
            default:
            begin
                cur.last = 1'b1;
            end
        endcase
    end

    // Load the next field when idle or on the final byte of this one
    assign pop         = !empty && (!active_reg || cur.last);
    assign active_next = pop ? 1'b1 : (active_reg && !cur.last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            valid_reg  <= active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= cur;
        if (pop)
        begin
            mode_reg  <= head.mode;
            data_reg  <= head.data;
            count_reg <= head.count;
            xr_reg    <= head.xr;
            pos_reg   <= head.pos;
        end
        else if (active_reg)
        begin
            data_reg  <= data_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && mode_reg != MODE_VAR) |-> (count_reg != 4'd0))
        else $error("active fixed-width field with no bytes left");

    a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
        $past(active_reg) == valid_reg)
        else $error("result strobe out of step with emitter");

endmodule

>>> hw/rtl/obfuscated_field_serializer_unit.sv
// Masked field serializer. Raise start with an item (kind, 64-bit value) while
// busy is low; the field goes out as 1 to 10 bytes on result, one byte per
// clock, each marked by result_valid for exactly one cycle, with result.last
// set on the final byte. The receiver cannot stall the block, so it must take
// every strobed byte. An item has as many bytes as its kind gives (uint8 1,
// uint16 2, uint32 and float32 4, uint64 and float64 8, varuint 1 to 10); the
// single byte emitter in the back end sends them; queued fields follow each
// other without gaps. The emitter loads a field from the queue and registers
// each byte onto result. A queue of QUEUE_DEPTH classified fields sits
// between the front end and the emitter; busy is high while it is full. Kind 7
// is dropped and sends nothing. Write mask_byte (index 0) and wide_mask_byte
// (index 1) only while no field is in flight; cfg_ready is always high and
// writes to other indexes are ignored.
module obfuscated_field_serializer_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  ofs_pkg::item_t                  item,
    output logic                            result_valid,
    output ofs_pkg::result_t                result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ofs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                      cfg_data
);
    import ofs_pkg::*;

    logic accept;
    logic push;
    logic pop;
    logic empty;
    logic full;
    cmd_t push_cmd;
    cmd_t head;

    // Hold off new words only while the queue has no room
    assign busy      = full;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // Classify the item and apply the configured masks
    ofs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .cmd       (push_cmd)
    );

    // Buffer classified fields so the front can run ahead of the emitter
    ofs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    // Emit one byte per clock from the field at the head
    ofs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
